/* sv/shfr_pkg.sv */
// Package: shared widths and the per-byte result record of the frame receiver.
`default_nettype none
package shfr_pkg;

  localparam int LINK_W = 2;   // link selector width
  localparam int BYTE_W = 8;   // received byte width
  localparam int POS_W  = 8;   // frame position width

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             stored;
    logic             frame_end;
    logic             checksum_ok;
  } shfr_result_t;

endpackage
`default_nettype wire

/* sv/shfr_link_ctx.sv */
// Per-link frame position and running sum, and the per-byte decision logic.
`default_nettype none
module shfr_link_ctx #(
  parameter int HEADER_LEN = 4,
  parameter int FRAME_LEN  = 195,
  parameter int NUM_LINKS  = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       upd,
  input  wire logic [shfr_pkg::LINK_W-1:0] link,
  input  wire logic [shfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [shfr_pkg::BYTE_W-1:0] hdr_byte,
  output shfr_pkg::shfr_result_t          result
);
  import shfr_pkg::*;

  localparam int LAST_POS_I = FRAME_LEN - 1;
  localparam int HDR_END_I  = (HEADER_LEN < LAST_POS_I) ? HEADER_LEN : LAST_POS_I;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(LAST_POS_I);
  localparam logic [POS_W-1:0] HDR_END  = POS_W'(HDR_END_I);

  logic [POS_W-1:0]  frame_pos   [NUM_LINKS];
  logic [BYTE_W-1:0] running_sum [NUM_LINKS];

  logic              link_ok;
  logic [POS_W-1:0]  pos_sel;
  logic [BYTE_W-1:0] sum_sel;
  logic [POS_W-1:0]  pos_next;
  logic [BYTE_W-1:0] sum_next;

  assign link_ok = ({1'b0, link} < (LINK_W+1)'(NUM_LINKS));

  always_comb begin
    pos_sel = '0;
    sum_sel = '0;
    for (int l = 0; l < NUM_LINKS; l++) begin
      if (link == LINK_W'(l)) begin
        pos_sel = frame_pos[l];
        sum_sel = running_sum[l];
      end
    end
  end

  always_comb begin
    result   = '0;
    pos_next = pos_sel;
    sum_next = sum_sel;
    if (link_ok) begin
      priority if (pos_sel < HDR_END) begin
        if (rx_byte == hdr_byte) begin
          result.position = pos_sel;
          result.stored   = 1'b1;
          pos_next        = pos_sel + POS_W'(1);
        end else begin
          pos_next = '0;   // bad header byte: restart hunt
        end
      end else if (pos_sel < LAST_POS) begin
        result.position = pos_sel;
        result.stored   = 1'b1;
        pos_next        = pos_sel + POS_W'(1);
        sum_next        = sum_sel + rx_byte;
      end else if (pos_sel == LAST_POS) begin
        result.position    = pos_sel;
        result.stored      = 1'b1;
        result.frame_end   = 1'b1;
        result.checksum_ok = (rx_byte == sum_sel);
        pos_next           = '0;
        sum_next           = '0;
      end else begin
        pos_next = '0;
        sum_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_LINKS; l++) begin
      if (rst) begin
        frame_pos[l]   <= '0;
        running_sum[l] <= '0;
      end else if (upd && link_ok && (link == LINK_W'(l))) begin
        frame_pos[l]   <= pos_next;
        running_sum[l] <= sum_next;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/sync_header_frame_receiver_core.sv */
// Top level: multi-link fixed-length frame receiver with header hunt and sum8 check.
// Pipeline: an accepted byte is held in the input register, then its result in the result register;
//   a stalled result stream holds both registers.
// Throughput: one byte per cycle without result stalls; the per-link context update and the
//   result register are written at the same edge, so consecutive bytes on one link chain.
// Reset (rst, sync): all links hunt for a header at position 0 with zero sum,
//   the header match value hdr_reg returns to 0xAA, both pipeline registers are emptied.
`default_nettype none
module sync_header_frame_receiver_core #(
  parameter int HEADER_LEN = 4,
  parameter int FRAME_LEN  = 195,
  parameter int NUM_LINKS  = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        header_byte_we,
  input  wire logic [shfr_pkg::BYTE_W-1:0] header_byte,
  // input stream
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [shfr_pkg::LINK_W-1:0] s_axis_tuser,   // [1:0] link
  // result stream
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output      logic [15:0]                 m_axis_tdata,   // [1:0] out_link, [9:2] position, zero
  output      logic                        m_axis_tlast,   // frame_end
  output      logic [1:0]                  m_axis_tuser    // [0] stored, [1] checksum_ok
);
  import shfr_pkg::*;

  // header match value
  logic [BYTE_W-1:0] hdr_reg;

  // input register stage
  logic              in_valid;
  logic [LINK_W-1:0] in_link;
  logic [BYTE_W-1:0] in_byte;

  // result register stage
  logic              out_valid;
  logic [LINK_W-1:0] out_link;
  shfr_result_t      out_res;

  shfr_result_t      res_next;
  logic              advance;

  // Input stage moves on when the result register is empty or draining.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_reg <= 8'hAA;
    end else if (header_byte_we) begin
      hdr_reg <= header_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_link <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  // Per-link context: read in the cycle the byte sits in the input register,
  // written back at the edge the byte moves to the result register.
  shfr_link_ctx #(
    .HEADER_LEN (HEADER_LEN),
    .FRAME_LEN  (FRAME_LEN),
    .NUM_LINKS  (NUM_LINKS)
  ) u_ctx (
    .clk      (clk),
    .rst      (rst),
    .upd      (advance),
    .link     (in_link),
    .rx_byte  (in_byte),
    .hdr_byte (hdr_reg),
    .result   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_link <= in_link;
      out_res  <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_res.position, out_link};
  assign m_axis_tlast  = out_res.frame_end;
  assign m_axis_tuser  = {out_res.checksum_ok, out_res.stored};

  // Checks on the decision logic
  a_end_is_stored: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
    else $error("frame end without stored byte");

  a_ok_needs_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
    else $error("checksum ok outside frame end");

  a_unstored_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[9:2] == '0))
    else $error("position nonzero for unstored byte");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
